[rtl/core/candidate_window_chunk_splitter_defines.svh]
// Assertion macros for the candidate window chunk splitter.
`ifndef CANDIDATE_WINDOW_CHUNK_SPLITTER_DEFINES_SVH
`define CANDIDATE_WINDOW_CHUNK_SPLITTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define CWCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwcs: same-cycle check failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define CWCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwcs: next-cycle check failed");
`else
`define CWCS_ASSERT_IMP(label, ante, cons)
`define CWCS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/core/cwcs_pkg.sv]
// Shared widths, codes and control types of the candidate window chunk splitter.
package cwcs_pkg;

    localparam int FIELD_W   = 48;
    localparam int SPAN_W    = 17;
    localparam int KEY_W     = 16;
    localparam int ERR_W     = 16;
    localparam int TMPL_W    = 20;
    localparam int SUM_W     = 21;
    localparam int WIN_W     = 18;
    localparam int OVL_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_CHUNKS_DEF = 64;
    localparam int POS_BITS_DEF   = 48;

    localparam logic [CFG_IDX_W-1:0] REG_EXT_SPAN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TMPL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_BASE  = 3'd4;

    localparam logic [SPAN_W-1:0]  SPAN_RST = 17'd0;
    localparam logic [KEY_W-1:0]   KEY_RST  = 16'd100;
    localparam logic [ERR_W-1:0]   ERR_RST  = 16'd0;
    localparam logic [TMPL_W-1:0]  TMPL_RST = 20'd1000;
    localparam logic [FIELD_W-1:0] BASE_RST = 48'd0;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLAMP  = 3'd2;
    localparam logic [OP_W-1:0] OP_LEN    = 3'd3;
    localparam logic [OP_W-1:0] OP_PROJ   = 3'd4;
    localparam logic [OP_W-1:0] OP_CURSOR = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd6;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_WIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OVL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              trunc;
    } cwcs_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic rem_ge_win;
        logic rmw_ge_win;
        logic rmw_gt_ovl;
        logic win_zero;
        logic at_limit;
    } cwcs_status_t;

endpackage

[rtl/core/cwcs_if.sv]
// Handshake interfaces for the configuration, region and chunk channels.
interface cwcs_cfg_if import cwcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface cwcs_region_if import cwcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] ext_begin;
    logic [FIELD_W-1:0] interval_begin;
    logic [FIELD_W-1:0] interval_end;

    modport source (output valid, output ext_begin, output interval_begin,
                    output interval_end, input ready);
    modport sink (input valid, input ext_begin, input interval_begin,
                  input interval_end, output ready);
endinterface

interface cwcs_chunk_if import cwcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] chunk_begin;
    logic [FIELD_W-1:0] chunk_end;
    logic               last_chunk;
    logic               truncated;

    modport source (output valid, output chunk_begin, output chunk_end,
                    output last_chunk, output truncated, input ready);
    modport sink (input valid, input chunk_begin, input chunk_end,
                  input last_chunk, input truncated, output ready);
endinterface

[rtl/core/cwcs_ctrl.sv]
// Sequencer: setup steps, chunk kind order, last and truncation flags.
module cwcs_ctrl import cwcs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cwcs_status_t status,
    output cwcs_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLAMP  = 3'd1;
    localparam logic [2:0] ST_LEN    = 3'd2;
    localparam logic [2:0] ST_PROJ   = 3'd3;
    localparam logic [2:0] ST_CURSOR = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [KIND_W-1:0] follow_kind;
    logic              has_follow;

    // work out which chunk comes after the one being loaded now
    always_comb
    begin
        has_follow  = 1'b0;
        follow_kind = KIND_TAIL;
        case (kind_reg)
            KIND_OVL:
            begin
                has_follow  = 1'b1;
                follow_kind = KIND_WIN;
            end
            KIND_WIN:
            begin
                if (status.rmw_ge_win)
                begin
                    has_follow  = 1'b1;
                    // a zero-length window never moves the cursor: no overlap chunks
                    follow_kind = status.win_zero ? KIND_WIN : KIND_OVL;
                end
                else if (status.rmw_gt_ovl)
                begin
                    has_follow  = 1'b1;
                    follow_kind = KIND_TAIL;
                end
            end
            default:
            begin
                has_follow = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.op     = OP_NONE;
        cmd.kind   = kind_reg;
        cmd.last   = !has_follow || status.at_limit;
        cmd.trunc  = has_follow && status.at_limit;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.op = OP_LOAD;
                if (status.in_valid)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.op     = OP_LEN;
                state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.op     = OP_PROJ;
                state_next = ST_CURSOR;
            end
            ST_CURSOR:
            begin
                cmd.op     = OP_CURSOR;
                kind_next  = status.rem_ge_win ? KIND_WIN : KIND_TAIL;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        kind_next = follow_kind;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_TAIL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[rtl/core/cwcs_datapath.sv]
// Datapath: configuration registers, region setup arithmetic, cursor and output register.
module cwcs_datapath import cwcs_pkg::*; #(
    parameter int MAX_CHUNKS    = MAX_CHUNKS_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cwcs_cfg_if.sink     cfg,
    cwcs_region_if.sink  region,
    cwcs_chunk_if.source chunk,
    input  cwcs_cmd_t    cmd,
    output cwcs_status_t status
);

    localparam int P     = POSITION_BITS;
    localparam int PX    = POSITION_BITS + 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    logic [SPAN_W-1:0]  span_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [TMPL_W-1:0]  tmpl_reg;
    logic [FIELD_W-1:0] base_reg;

    logic [P-1:0]      eb_reg, ib_reg, ie_reg;
    logic [PX-1:0]     ebe_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [OVL_W-1:0]  ovl_reg;
    logic [P-1:0]      cb_reg, ce_reg, len_reg, pb_reg, pe_reg;
    logic [PX-1:0]     pd_reg;
    logic [P-1:0]      cur_reg, cpw_reg, rem_reg, rmw_reg, off_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [P-1:0]      ob_reg, oe_reg;
    logic              olast_reg, otrunc_reg, ovalid_reg;

    logic          take;
    logic          out_free;
    logic [P-1:0]  win_p, ovl_p, base_p;
    logic [PX-1:0] end_sum, len_diff, proj_diff, pb_diff, ovl_reach;
    logic [P-1:0]  emit_begin, emit_end;

    assign cfg.ready    = 1'b1;
    assign region.ready = (cmd.op == OP_LOAD);
    assign take         = region.valid && region.ready;
    assign out_free     = !ovalid_reg || chunk.ready;

    assign win_p  = P'(win_reg);
    assign ovl_p  = P'(ovl_reg);
    assign base_p = P'(base_reg);

    assign end_sum   = PX'(eb_reg) + PX'(sum_reg);
    assign len_diff  = PX'(ce_reg) - PX'(cb_reg);
    assign proj_diff = PX'(base_p) - PX'(cb_reg);
    assign pb_diff   = PX'(pd_reg[P-1:0]) - PX'(len_reg);
    assign ovl_reach = PX'(cur_reg) + PX'(ovl_reg);

    always_comb
    begin
        case (cmd.kind)
            KIND_WIN:
            begin
                emit_begin = cur_reg;
                emit_end   = cpw_reg;
            end
            KIND_OVL:
            begin
                // clip the overlap to the projected region on both sides
                emit_begin = (off_reg > ovl_p) ? (cur_reg - ovl_p) : pb_reg;
                emit_end   = (rem_reg > ovl_p) ? ovl_reach[P-1:0] : pe_reg;
            end
            KIND_TAIL:
            begin
                emit_begin = cur_reg;
                emit_end   = pe_reg;
            end
            default:
            begin
                emit_begin = cur_reg;
                emit_end   = pe_reg;
            end
        endcase
    end

    assign status.in_valid   = region.valid;
    assign status.out_free   = out_free;
    assign status.rem_ge_win = (rem_reg >= win_p);
    assign status.rmw_ge_win = (rmw_reg >= win_p);
    assign status.rmw_gt_ovl = (rmw_reg > ovl_p);
    assign status.win_zero   = (win_reg == '0);
    assign status.at_limit   = (cnt_reg == CNT_W'(MAX_CHUNKS - 1));

    assign chunk.valid       = ovalid_reg;
    assign chunk.chunk_begin = FIELD_W'(ob_reg);
    assign chunk.chunk_end   = FIELD_W'(oe_reg);
    assign chunk.last_chunk  = olast_reg;
    assign chunk.truncated   = otrunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RST;
            key_reg  <= KEY_RST;
            err_reg  <= ERR_RST;
            tmpl_reg <= TMPL_RST;
            base_reg <= BASE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_EXT_SPAN:   span_reg <= cfg.data[SPAN_W-1:0];
                REG_KEY_LENGTH: key_reg  <= cfg.data[KEY_W-1:0];
                REG_MAX_ERROR:  err_reg  <= cfg.data[ERR_W-1:0];
                REG_MAX_TMPL:   tmpl_reg <= cfg.data[TMPL_W-1:0];
                REG_PROJ_BASE:  base_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.op == OP_EMIT)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.op == OP_EMIT)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (chunk.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            eb_reg  <= P'(region.ext_begin);
            ib_reg  <= P'(region.interval_begin);
            ie_reg  <= P'(region.interval_end);
            ebe_reg <= PX'(P'(region.ext_begin)) - PX'(err_reg);
            sum_reg <= SUM_W'(span_reg) + SUM_W'(tmpl_reg) + SUM_W'(key_reg)
                       + SUM_W'(err_reg);
            win_reg <= WIN_W'(key_reg) + (WIN_W'(err_reg) << 1);
            ovl_reg <= OVL_W'(key_reg) + OVL_W'(err_reg);
        end
        case (cmd.op)
            OP_CLAMP:
            begin
                // floor the begin at the interval, cap the end at it
                cb_reg <= (!ebe_reg[P] && (ebe_reg[P-1:0] > ib_reg)) ? ebe_reg[P-1:0]
                                                                     : ib_reg;
                ce_reg <= (end_sum < PX'(ie_reg)) ? end_sum[P-1:0] : ie_reg;
            end
            OP_LEN:
            begin
                // an inverted region collapses to zero length
                len_reg <= len_diff[P] ? '0 : len_diff[P-1:0];
                pd_reg  <= proj_diff;
            end
            OP_PROJ:
            begin
                // saturate the projected begin at zero on underflow
                pb_reg  <= (!pd_reg[P] && !pb_diff[P]) ? pb_diff[P-1:0] : '0;
                rem_reg <= len_reg;
                rmw_reg <= len_reg - win_p;
                off_reg <= '0;
            end
            OP_CURSOR:
            begin
                pe_reg  <= pb_reg + len_reg;
                cur_reg <= pb_reg;
                cpw_reg <= pb_reg + win_p;
            end
            OP_EMIT:
            begin
                ob_reg     <= emit_begin;
                oe_reg     <= emit_end;
                olast_reg  <= cmd.last;
                otrunc_reg <= cmd.trunc;
                if (cmd.kind == KIND_WIN)
                begin
                    // advance the cursor by one window
                    cur_reg <= cpw_reg;
                    cpw_reg <= cpw_reg + win_p;
                    rem_reg <= rmw_reg;
                    rmw_reg <= rmw_reg - win_p;
                    off_reg <= off_reg + win_p;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/candidate_window_chunk_splitter.sv]
// Top level of the candidate window chunk splitter: sequencer, datapath and checks.
// After an item is taken, the clamp, length, projection and cursor steps run in order
// before its first chunk is offered. Throughput: one chunk per cycle while the output is
// taken; an item with n chunks (n up to MAX_CHUNKS) holds the block for the four serial
// setup steps and the one-chunk-per-cycle emit loop around the cursor registers.
// Reset clears the sequencer and output valid and loads the register defaults.
`include "candidate_window_chunk_splitter_defines.svh"
module candidate_window_chunk_splitter import cwcs_pkg::*; #(
    parameter int MAX_CHUNKS    = MAX_CHUNKS_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cwcs_cfg_if.sink     cfg,
    cwcs_region_if.sink  region,
    cwcs_chunk_if.source chunk
);

    cwcs_cmd_t    cmd;
    cwcs_status_t status;

    cwcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    cwcs_datapath #(
        .MAX_CHUNKS    (MAX_CHUNKS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .region (region),
        .chunk  (chunk),
        .cmd    (cmd),
        .status (status)
    );

    `CWCS_ASSERT_NXT(a_take_blocks_next, region.valid && region.ready, !region.ready)
    `CWCS_ASSERT_IMP(a_emit_has_room, cmd.op == OP_EMIT, !chunk.valid || chunk.ready)
    `CWCS_ASSERT_NXT(a_last_frees_input, cmd.op == OP_EMIT && cmd.last, region.ready)

endmodule
